>>> rtl/m4inv_pkg.sv
// Shared constants, command types and cofactor term lookup for the 4x4 inverse block.
`timescale 1ns / 1ps
package m4inv_pkg;

	// Fixed-point format and internal widths
	localparam int FRAC_BITS = 16;
	localparam int EW        = 32;                      // element width
	localparam int QW        = EW + 1;                  // multiplier operand / quotient width
	localparam int PW        = 2 * QW;                  // product width
	localparam int CW        = 100;                     // cofactor width (exact)
	localparam int ACC_W     = 132;                     // accumulator / determinant width
	localparam int DW        = ACC_W + 1;               // divisor width (2*|det|)
	localparam int NW_A      = CW + 2 * FRAC_BITS + 2;
	localparam int NW        = (NW_A > DW) ? NW_A : DW; // dividend width
	localparam int SING_EXP  = (4 * FRAC_BITS > 40) ? 4 * FRAC_BITS - 40 : 0;
	localparam int LAST_TERM = 5;
	localparam logic [EW-1:0] ONE = EW'(1) << FRAC_BITS;

	// Source of multiplier operand B
	typedef enum logic [2:0] {
		B_NONE,
		B_ELEM,
		B_PLO,
		B_PHI,
		B_COF
	} bsrc_t;

	// Datapath command, decoded by the controller every cycle
	typedef struct packed {
		logic             mem_we;
		logic [1:0]       ra_col;
		logic [1:0]       rb_col;
		logic [1:0]       a_row;
		logic [1:0]       b_row;
		logic             ld_a;
		bsrc_t            b_src;
		logic             mul;
		logic             acc_add;
		logic             acc_neg;
		logic [1:0]       acc_sh;
		logic             acc_clr;
		logic             cof_wr;
		logic [3:0]       cof_idx;
		logic [1:0]       chunk;
		logic             det_wr;
		logic             det_abs;
		logic             sing_chk;
		logic             div_abs;
		logic             div_num;
		logic             div_ovf;
		logic             div_step;
		logic             div_wr;
		logic [1:0]       res_row;
		logic             out_load;
		logic [1:0]       out_col;
	} dp_cmd_t;

	// Datapath status back to the controller
	typedef struct packed {
		logic sing;
		logic out_room;
	} dp_stat_t;

	// One triple product of a 3x3 minor: x * y * z, negated when neg
	typedef struct packed {
		logic [1:0] x_col;
		logic [1:0] x_row;
		logic [1:0] y_col;
		logic [1:0] y_row;
		logic [1:0] z_col;
		logic [1:0] z_row;
		logic       neg;
	} term_t;

	// n-th index of 0..3 with gap left out
	function automatic logic [1:0] skip_idx(input logic [1:0] gap, input logic [1:0] n);
		return (n < gap) ? n : n + 2'd1;
	endfunction

	function automatic logic [1:0] next_mod3(input logic [1:0] k);
		logic [1:0] r;
		case (k)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

	// Term t (0..5) of cofactor idx = col*4+row; the minor leaves out row col, column row
	function automatic term_t cof_term(input logic [3:0] idx, input logic [2:0] t);
		logic [1:0] sr;
		logic [1:0] sc;
		logic [1:0] k;
		logic [1:0] ka;
		logic [1:0] kb;
		term_t      tm;
		sr = idx[3:2];
		sc = idx[1:0];
		k  = t[2:1];
		ka = next_mod3(k);
		kb = next_mod3(ka);
		tm.z_row = skip_idx(sr, 2'd0);
		tm.z_col = skip_idx(sc, k);
		tm.x_row = skip_idx(sr, 2'd1);
		tm.y_row = skip_idx(sr, 2'd2);
		if (!t[0]) begin
			tm.x_col = skip_idx(sc, ka);
			tm.y_col = skip_idx(sc, kb);
		end else begin
			tm.x_col = skip_idx(sc, kb);
			tm.y_col = skip_idx(sc, ka);
		end
		tm.neg = t[0] ^ idx[2] ^ idx[0];
		return tm;
	endfunction

endpackage

>>> rtl/m4inv_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module m4inv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

>>> rtl/m4inv_dp.sv
// Datapath: matrix store, shared multiplier, accumulator, cofactors and serial divider.
`timescale 1ns / 1ps
module m4inv_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  m4inv_pkg::dp_cmd_t         cmd,
	output m4inv_pkg::dp_stat_t        stat,
	input  logic [1:0]                 col,
	input  logic signed [31:0]         elem_row0,
	input  logic signed [31:0]         elem_row1,
	input  logic signed [31:0]         elem_row2,
	input  logic signed [31:0]         elem_row3,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic [1:0]                 out_col,
	output logic signed [31:0]         res_row0,
	output logic signed [31:0]         res_row1,
	output logic signed [31:0]         res_row2,
	output logic signed [31:0]         res_row3,
	output logic                       singular,
	output logic                       last
);

	localparam int EW    = m4inv_pkg::EW;
	localparam int QW    = m4inv_pkg::QW;
	localparam int PW    = m4inv_pkg::PW;
	localparam int CW    = m4inv_pkg::CW;
	localparam int ACC_W = m4inv_pkg::ACC_W;
	localparam int DW    = m4inv_pkg::DW;
	localparam int NW    = m4inv_pkg::NW;

	logic [4*EW-1:0]           ram_a;
	logic [4*EW-1:0]           ram_b;
	logic signed [EW-1:0]      elem_a;
	logic signed [EW-1:0]      elem_b;

	logic signed [QW-1:0]      opa_q;
	logic signed [QW-1:0]      opb_q;
	logic signed [PW-1:0]      prod_q;
	logic signed [EW-1:0]      hi_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [CW-1:0]             cof_q [16];
	logic signed [ACC_W-1:0]   det_q;
	logic [ACC_W-1:0]          dmag_q;
	logic                      dneg_q;
	logic                      sing_q;
	logic [CW-1:0]             cmag_q;
	logic                      qneg_q;
	logic [NW-1:0]             num_q;
	logic                      ovf_q;
	logic [DW-1:0]             rem_q;
	logic [QW-1:0]             qsh_q;
	logic [QW-1:0]             quot_q;
	logic [EW-1:0]             res_q [4];
	logic                      out_valid_q;

	logic [CW-1:0]             cof_rd;
	logic signed [QW-1:0]      cof_chunk;
	logic signed [ACC_W-1:0]   addend;
	logic [DW-1:0]             den;
	logic [DW:0]               trial;
	logic [QW-1:0]             lim;
	logic [QW-1:0]             mag;
	logic [EW-1:0]             qval;

	// column store, one column per entry
	m4inv_ram #(
		.WIDTH(4 * EW),
		.DEPTH(4)
	) u_store (
		.clk    (clk),
		.we     (cmd.mem_we),
		.waddr  (col),
		.wdata  ({elem_row3, elem_row2, elem_row1, elem_row0}),
		.raddr_a(cmd.ra_col),
		.rdata_a(ram_a),
		.raddr_b(cmd.rb_col),
		.rdata_b(ram_b)
	);

	// element and cofactor chunk selection
	always_comb begin
		elem_a = ram_a[{cmd.a_row, 5'b0} +: EW];
		elem_b = ram_b[{cmd.b_row, 5'b0} +: EW];
		cof_rd = cof_q[cmd.cof_idx];
		case (cmd.chunk)
			2'd0:    cof_chunk = {1'b0, cof_rd[0 +: EW]};
			2'd1:    cof_chunk = {1'b0, cof_rd[EW +: EW]};
			2'd2:    cof_chunk = {1'b0, cof_rd[2*EW +: EW]};
			default: cof_chunk = QW'($signed(cof_rd[CW-1:3*EW]));
		endcase
		addend = ACC_W'(prod_q) << {cmd.acc_sh, 5'b0};
	end

	// divider helpers
	always_comb begin
		den   = {dmag_q, 1'b0};
		trial = {rem_q, qsh_q[QW-1]};
		lim   = qneg_q ? (QW'(1) << (EW - 1)) : ((QW'(1) << (EW - 1)) - QW'(1));
		mag   = (ovf_q || quot_q > lim) ? lim : quot_q;
		qval  = qneg_q ? (EW'(0) - mag[EW-1:0]) : mag[EW-1:0];
	end

	// multiplier, accumulator, cofactor and determinant registers
	always_ff @(posedge clk) begin
		if (cmd.ld_a) begin
			opa_q <= QW'(elem_a);
		end
		case (cmd.b_src)
			m4inv_pkg::B_ELEM: opb_q <= QW'(elem_b);
			m4inv_pkg::B_PLO: begin
				opb_q <= {1'b0, prod_q[EW-1:0]};
				hi_q  <= prod_q[2*EW-1:EW];
			end
			m4inv_pkg::B_PHI:  opb_q <= QW'(hi_q);
			m4inv_pkg::B_COF:  opb_q <= cof_chunk;
			default: ;
		endcase
		if (cmd.mul) begin
			prod_q <= opa_q * opb_q;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= cmd.acc_neg ? acc_q - addend : acc_q + addend;
		end
		if (cmd.cof_wr) begin
			cof_q[cmd.cof_idx] <= acc_q[CW-1:0];
		end
		if (cmd.det_wr) begin
			det_q <= acc_q;
		end
		if (cmd.det_abs) begin
			dneg_q <= det_q[ACC_W-1];
			dmag_q <= det_q[ACC_W-1] ? ACC_W'(-det_q) : ACC_W'(det_q);
		end
		if (cmd.sing_chk) begin
			sing_q <= dmag_q < (ACC_W'(1) << m4inv_pkg::SING_EXP);
		end
	end

	// serial restoring divider, one quotient bit per step
	always_ff @(posedge clk) begin
		if (cmd.div_abs) begin
			qneg_q <= cof_rd[CW-1] ^ dneg_q;
			cmag_q <= cof_rd[CW-1] ? (CW'(0) - cof_rd) : cof_rd;
		end
		if (cmd.div_num) begin
			num_q <= (NW'(cmag_q) << (2 * m4inv_pkg::FRAC_BITS + 1)) + NW'(dmag_q);
		end
		if (cmd.div_ovf) begin
			ovf_q  <= (num_q >> QW) >= NW'(den);
			rem_q  <= DW'(num_q >> QW);
			qsh_q  <= num_q[QW-1:0];
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			qsh_q <= {qsh_q[QW-2:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				rem_q  <= DW'(trial - {1'b0, den});
				quot_q <= {quot_q[QW-2:0], 1'b1};
			end else begin
				rem_q  <= trial[DW-1:0];
				quot_q <= {quot_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.div_wr) begin
			res_q[cmd.res_row] <= qval;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_col  <= cmd.out_col;
			singular <= sing_q;
			last     <= (cmd.out_col == 2'd3);
			res_row0 <= sing_q ? ((cmd.out_col == 2'd0) ? m4inv_pkg::ONE : '0) : res_q[0];
			res_row1 <= sing_q ? ((cmd.out_col == 2'd1) ? m4inv_pkg::ONE : '0) : res_q[1];
			res_row2 <= sing_q ? ((cmd.out_col == 2'd2) ? m4inv_pkg::ONE : '0) : res_q[2];
			res_row3 <= sing_q ? ((cmd.out_col == 2'd3) ? m4inv_pkg::ONE : '0) : res_q[3];
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign stat.sing     = sing_q;
	assign stat.out_room = !out_valid_q || !out_stall;

endmodule

>>> rtl/m4inv_ctrl.sv
// Controller: sequences cofactor terms, determinant, division and output columns.
`timescale 1ns / 1ps
module m4inv_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           col,
	input  m4inv_pkg::dp_stat_t  stat,
	output m4inv_pkg::dp_cmd_t   cmd
);

	typedef enum logic [4:0] {
		S_IDLE,
		S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7,
		S_CW,
		S_DRD, S_DLA, S_DLB, S_DMUL, S_DACC, S_DWR,
		S_DABS, S_SING,
		S_COL, S_VA, S_VN, S_VO, S_VI, S_VW,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [3:0]          idx_q;
	logic [2:0]          term_q;
	logic [1:0]          sub_q;
	logic [5:0]          it_q;
	m4inv_pkg::term_t    tm;

	assign tm       = m4inv_pkg::cof_term(idx_q, term_q);
	assign in_stall = (state_q != S_IDLE);

	// command decode
	always_comb begin
		cmd         = '0;
		cmd.cof_idx = idx_q;
		cmd.chunk   = sub_q;
		cmd.res_row = idx_q[1:0];
		cmd.out_col = idx_q[3:2];
		unique case (state_q)
			S_IDLE: begin
				cmd.mem_we  = in_valid;
				cmd.acc_clr = in_valid;
			end
			S_T0: begin
				cmd.ra_col = tm.x_col;
				cmd.rb_col = tm.y_col;
			end
			S_T1: begin
				cmd.ld_a   = 1'b1;
				cmd.a_row  = tm.x_row;
				cmd.b_src  = m4inv_pkg::B_ELEM;
				cmd.b_row  = tm.y_row;
				cmd.ra_col = tm.z_col;
			end
			S_T2: begin
				cmd.mul    = 1'b1;
				cmd.ld_a   = 1'b1;
				cmd.a_row  = tm.z_row;
				cmd.ra_col = tm.z_col;
			end
			S_T3: cmd.b_src = m4inv_pkg::B_PLO;
			S_T4: cmd.mul = 1'b1;
			S_T5: begin
				cmd.acc_add = 1'b1;
				cmd.acc_neg = tm.neg;
				cmd.b_src   = m4inv_pkg::B_PHI;
			end
			S_T6: cmd.mul = 1'b1;
			S_T7: begin
				cmd.acc_add = 1'b1;
				cmd.acc_neg = tm.neg;
				cmd.acc_sh  = 2'd1;
			end
			S_CW: begin
				cmd.cof_wr  = 1'b1;
				cmd.acc_clr = 1'b1;
			end
			S_DRD: cmd.ra_col = idx_q[1:0];
			S_DLA: begin
				cmd.ra_col = idx_q[1:0];
				cmd.ld_a   = 1'b1;
			end
			S_DLB: cmd.b_src = m4inv_pkg::B_COF;
			S_DMUL: cmd.mul = 1'b1;
			S_DACC: begin
				cmd.acc_add = 1'b1;
				cmd.acc_sh  = sub_q;
			end
			S_DWR:  cmd.det_wr = 1'b1;
			S_DABS: cmd.det_abs = 1'b1;
			S_SING: cmd.sing_chk = 1'b1;
			S_COL: ;
			S_VA:  cmd.div_abs = 1'b1;
			S_VN:  cmd.div_num = 1'b1;
			S_VO:  cmd.div_ovf = 1'b1;
			S_VI:  cmd.div_step = 1'b1;
			S_VW:  cmd.div_wr = 1'b1;
			S_OUT: cmd.out_load = stat.out_room;
			default: ;
		endcase
	end

	// state and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			term_q  <= '0;
			sub_q   <= '0;
			it_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && col == 2'd3) begin
						idx_q   <= '0;
						term_q  <= '0;
						state_q <= S_T0;
					end
				end
				S_T0: state_q <= S_T1;
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= S_T4;
				S_T4: state_q <= S_T5;
				S_T5: state_q <= S_T6;
				S_T6: state_q <= S_T7;
				S_T7: begin
					if (term_q == 3'(m4inv_pkg::LAST_TERM)) begin
						state_q <= S_CW;
					end else begin
						term_q  <= term_q + 3'd1;
						state_q <= S_T0;
					end
				end
				S_CW: begin
					term_q <= '0;
					sub_q  <= '0;
					if (idx_q == 4'd15) begin
						idx_q   <= '0;
						state_q <= S_DRD;
					end else begin
						idx_q   <= idx_q + 4'd1;
						state_q <= S_T0;
					end
				end
				S_DRD:  state_q <= S_DLA;
				S_DLA:  state_q <= S_DLB;
				S_DLB:  state_q <= S_DMUL;
				S_DMUL: state_q <= S_DACC;
				S_DACC: begin
					sub_q <= sub_q + 2'd1;
					if (sub_q != 2'd3) begin
						state_q <= S_DLB;
					end else if (idx_q == 4'd3) begin
						state_q <= S_DWR;
					end else begin
						idx_q   <= idx_q + 4'd1;
						state_q <= S_DRD;
					end
				end
				S_DWR:  state_q <= S_DABS;
				S_DABS: state_q <= S_SING;
				S_SING: begin
					idx_q   <= '0;
					state_q <= S_COL;
				end
				S_COL: state_q <= stat.sing ? S_OUT : S_VA;
				S_VA:  state_q <= S_VN;
				S_VN:  state_q <= S_VO;
				S_VO: begin
					it_q    <= '0;
					state_q <= S_VI;
				end
				S_VI: begin
					if (it_q == 6'(m4inv_pkg::QW - 1)) begin
						state_q <= S_VW;
					end else begin
						it_q <= it_q + 6'd1;
					end
				end
				S_VW: begin
					if (idx_q[1:0] == 2'd3) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + 4'd1;
						state_q <= S_VA;
					end
				end
				S_OUT: begin
					if (stat.out_room) begin
						if (idx_q[3:2] == 2'd3) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= {idx_q[3:2] + 2'd1, 2'b00};
							state_q <= S_COL;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/matrix4x4_cofactor_inverse.sv
// Top level: 4x4 fixed-point matrix inverse by cofactors.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | col, elem_row0..elem_row3
//  out     | out_valid / out_stall| out_col, res_row0..res_row3, singular, last
//
// Columns 0..2 are written into the store as they arrive. Column 3 then runs on the
// shared 33x33 multiplier (16 cofactors x 6 terms x 8 steps, then 4x4 chunk
// products for the determinant) and the one-bit-per-cycle divider; a singular
// matrix skips the divider. Four results follow.
// Reset clears the controller and the output valid; the matrix store holds
// nothing defined until written. A stalled output holds the sequencer.
`timescale 1ns / 1ps
module matrix4x4_cofactor_inverse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         col,
	input  logic signed [31:0] elem_row0,
	input  logic signed [31:0] elem_row1,
	input  logic signed [31:0] elem_row2,
	input  logic signed [31:0] elem_row3,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         out_col,
	output logic signed [31:0] res_row0,
	output logic signed [31:0] res_row1,
	output logic signed [31:0] res_row2,
	output logic signed [31:0] res_row3,
	output logic               singular,
	output logic               last
);

	m4inv_pkg::dp_cmd_t  cmd;
	m4inv_pkg::dp_stat_t stat;

	// sequencer
	m4inv_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.col     (col),
		.stat    (stat),
		.cmd     (cmd)
	);

	// arithmetic and storage
	m4inv_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.col      (col),
		.elem_row0(elem_row0),
		.elem_row1(elem_row1),
		.elem_row2(elem_row2),
		.elem_row3(elem_row3),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_col  (out_col),
		.res_row0 (res_row0),
		.res_row1 (res_row1),
		.res_row2 (res_row2),
		.res_row3 (res_row3),
		.singular (singular),
		.last     (last)
	);

endmodule
